[hw/rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[hw/rtl/qyr_pkg.sv]
// types, constants and the arctangent table of the quaternion yaw rate block
package qyr_pkg;

  localparam int QYR_QW           = 16;   // quaternion component width
  localparam int QYR_TW           = 48;   // timestamp width
  localparam int QYR_RW           = 32;   // rate width
  localparam int QYR_YW           = 16;   // yaw width
  localparam int QYR_CW           = 36;   // cordic vector width
  localparam int QYR_AW           = 34;   // cordic angle width, scale 2^29
  localparam int QYR_PW           = 38;   // |dyaw| * rate scale
  localparam int QYR_MW           = 15;   // |yaw| and |dyaw| width
  localparam int QYR_ATAN_LEN     = 24;
  localparam int QYR_IDX_W        = $clog2(QYR_ATAN_LEN);
  localparam int QYR_DIV_BITS     = 32;   // quotient bits of the divider
  localparam int QYR_CNT_W        = $clog2(QYR_DIV_BITS);
  localparam int QYR_CORDIC_STEPS = 16;

  localparam logic signed [QYR_AW-1:0] QYR_PI_Q29     = 34'sd1686629713;
  localparam logic signed [QYR_YW-1:0] QYR_PI_Q13     = 16'sd25736;
  localparam logic signed [16:0]       QYR_TWO_PI_Q13 = 17'sd51472;
  localparam logic [QYR_PW-1:0]        QYR_RATE_SCALE = 38'd8000000;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_SUM,
    OP_PRE,
    OP_ROT,
    OP_RND1,
    OP_RND2,
    OP_YAW,
    OP_DIFF,
    OP_WRAP,
    OP_MAG,
    OP_MULT,
    OP_NUM,
    OP_SETUP,
    OP_DIV,
    OP_OUT
  } qyr_op_t;

  typedef struct packed {
    qyr_op_t               op;
    logic [QYR_IDX_W-1:0]  idx;
  } qyr_cmd_t;

  typedef struct packed {
    logic have_prev;
    logic dt_zero;
    logic ovf;
    logic out_free;
  } qyr_sts_t;

  // atan(2^-i) at scale 2^29
  function automatic logic signed [QYR_AW-1:0] atan_q29(input logic [QYR_IDX_W-1:0] idx);
    logic signed [QYR_AW-1:0] val;
    unique case (idx)
      5'd0:    val = 34'sd421657428;
      5'd1:    val = 34'sd248918915;
      5'd2:    val = 34'sd131521918;
      5'd3:    val = 34'sd66762579;
      5'd4:    val = 34'sd33510843;
      5'd5:    val = 34'sd16771758;
      5'd6:    val = 34'sd8387925;
      5'd7:    val = 34'sd4194219;
      5'd8:    val = 34'sd2097141;
      5'd9:    val = 34'sd1048575;
      5'd10:   val = 34'sd524288;
      5'd11:   val = 34'sd262144;
      5'd12:   val = 34'sd131072;
      5'd13:   val = 34'sd65536;
      5'd14:   val = 34'sd32768;
      5'd15:   val = 34'sd16384;
      5'd16:   val = 34'sd8192;
      5'd17:   val = 34'sd4096;
      5'd18:   val = 34'sd2048;
      5'd19:   val = 34'sd1024;
      5'd20:   val = 34'sd512;
      5'd21:   val = 34'sd256;
      5'd22:   val = 34'sd128;
      5'd23:   val = 34'sd64;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

[hw/rtl/qyr_ifs.sv]
// valid/ready channel interfaces for quaternion items and yaw rate results
interface qyr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qyr_pkg::QYR_QW-1:0]    quat_w;
  logic signed [qyr_pkg::QYR_QW-1:0]    quat_x;
  logic signed [qyr_pkg::QYR_QW-1:0]    quat_y;
  logic signed [qyr_pkg::QYR_QW-1:0]    quat_z;
  logic        [qyr_pkg::QYR_TW-1:0]    time_us;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, time_us, input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, time_us, output ready);
endinterface

interface qyr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qyr_pkg::QYR_RW-1:0]    yaw_rate;
  logic signed [qyr_pkg::QYR_YW-1:0]    yaw_now;
  logic                                 zero_interval;
  logic                                 rate_saturated;

  modport source (output valid, yaw_rate, yaw_now, zero_interval, rate_saturated,
                  input ready);
  modport sink   (input valid, yaw_rate, yaw_now, zero_interval, rate_saturated,
                  output ready);
endinterface

[hw/rtl/qyr_ctrl.sv]
// sequencer: steps the datapath through cordic, wrap, divide and output
module qyr_ctrl #(
  parameter int CORDIC_STEPS = qyr_pkg::QYR_CORDIC_STEPS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  qyr_pkg::qyr_sts_t sts,
  output logic              in_ready,
  output qyr_pkg::qyr_cmd_t cmd
);

  localparam int ROT_N = (CORDIC_STEPS > qyr_pkg::QYR_ATAN_LEN) ?
                         qyr_pkg::QYR_ATAN_LEN : CORDIC_STEPS;
  localparam logic [qyr_pkg::QYR_CNT_W-1:0] ROT_LAST = qyr_pkg::QYR_CNT_W'(ROT_N - 1);
  localparam logic [qyr_pkg::QYR_CNT_W-1:0] DIV_LAST =
    qyr_pkg::QYR_CNT_W'(qyr_pkg::QYR_DIV_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SUM, S_PRE, S_ROT, S_RND1, S_RND2, S_YAW,
    S_DIFF, S_WRAP, S_MAG, S_MULT, S_NUM, S_SETUP, S_DIV, S_OUT
  } state_t;

  state_t                          state_r, state_nxt;
  logic [qyr_pkg::QYR_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = qyr_pkg::OP_NONE;
    cmd.idx   = cnt_r[qyr_pkg::QYR_IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          cmd.op    = qyr_pkg::OP_LOAD;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op    = qyr_pkg::OP_MUL;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = qyr_pkg::OP_SUM;
        state_nxt = S_PRE;
      end
      S_PRE: begin
        cmd.op    = qyr_pkg::OP_PRE;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.op  = qyr_pkg::OP_ROT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ROT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_RND1;
        end
      end
      S_RND1: begin
        cmd.op    = qyr_pkg::OP_RND1;
        state_nxt = S_RND2;
      end
      S_RND2: begin
        cmd.op    = qyr_pkg::OP_RND2;
        state_nxt = S_YAW;
      end
      S_YAW: begin
        cmd.op    = qyr_pkg::OP_YAW;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        // first sample after reset only stores yaw and time
        cmd.op    = qyr_pkg::OP_DIFF;
        state_nxt = sts.have_prev ? S_WRAP : S_IDLE;
      end
      S_WRAP: begin
        cmd.op    = qyr_pkg::OP_WRAP;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        cmd.op    = qyr_pkg::OP_MAG;
        state_nxt = S_MULT;
      end
      S_MULT: begin
        cmd.op    = qyr_pkg::OP_MULT;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        cmd.op    = qyr_pkg::OP_NUM;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        // no divide when the interval is zero or the quotient cannot fit
        cmd.op    = qyr_pkg::OP_SETUP;
        cnt_nxt   = '0;
        state_nxt = (sts.dt_zero || sts.ovf) ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd.op  = qyr_pkg::OP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.op    = qyr_pkg::OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/qyr_dp.sv]
// datapath: products, cordic vectoring, yaw wrap, serial divide, output register
module qyr_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  qyr_pkg::qyr_cmd_t                  cmd,
  input  logic signed [qyr_pkg::QYR_QW-1:0]  quat_w,
  input  logic signed [qyr_pkg::QYR_QW-1:0]  quat_x,
  input  logic signed [qyr_pkg::QYR_QW-1:0]  quat_y,
  input  logic signed [qyr_pkg::QYR_QW-1:0]  quat_z,
  input  logic        [qyr_pkg::QYR_TW-1:0]  time_us,
  output qyr_pkg::qyr_sts_t                  sts,
  qyr_out_if.source                          out_ch
);

  localparam int QW = qyr_pkg::QYR_QW;
  localparam int TW = qyr_pkg::QYR_TW;
  localparam int RW = qyr_pkg::QYR_RW;
  localparam int YW = qyr_pkg::QYR_YW;
  localparam int CW = qyr_pkg::QYR_CW;
  localparam int AW = qyr_pkg::QYR_AW;
  localparam int PW = qyr_pkg::QYR_PW;
  localparam int MW = qyr_pkg::QYR_MW;
  localparam int DB = qyr_pkg::QYR_DIV_BITS;

  localparam logic signed [CW-1:0] C_ONE    = CW'(64'sd1 <<< 30);
  localparam logic        [AW:0]   RND_HALF = (AW+1)'(1 << 15);
  localparam logic        [AW-16:0] PI_RM   = (AW-15)'(qyr_pkg::QYR_PI_Q13);
  localparam logic signed [RW-1:0] RATE_MAX = {1'b0, {(RW-1){1'b1}}};
  localparam logic signed [RW-1:0] RATE_MIN = {1'b1, {(RW-1){1'b0}}};

  // input item and products
  logic signed [QW-1:0]    w_r, x_r, y_r, z_r;
  logic        [TW-1:0]    t_r;
  logic signed [2*QW-1:0]  pwz_r, pxy_r, pyy_r, pzz_r;
  // cordic
  logic signed [CW-1:0]    s_r, c_r;
  logic signed [AW-1:0]    ang_r;
  logic        [AW-1:0]    amag_r;
  logic                    aneg_r;
  logic        [MW-1:0]    ymag_r;
  logic signed [YW-1:0]    yaw_r;
  // stored sample
  logic signed [YW-1:0]    prev_yaw_r;
  logic        [TW-1:0]    prev_time_r;
  logic                    have_prev_r;
  // difference and divide
  logic signed [YW:0]      d_r;
  logic signed [YW-1:0]    dw_r;
  logic        [MW-1:0]    dabs_r;
  logic                    dneg_r;
  logic        [TW-1:0]    dt_r;
  logic        [PW-1:0]    prod_r;
  logic        [TW-1:0]    num_r;
  logic        [TW-1:0]    rem_r;
  logic        [DB-1:0]    nsh_r;
  logic        [DB-1:0]    q_r;
  logic                    ovf_r;
  // output register
  logic                    out_valid_r;
  logic signed [RW-1:0]    out_rate_r;
  logic signed [YW-1:0]    out_yaw_r;
  logic                    out_zero_r;
  logic                    out_sat_r;

  logic signed [2*QW:0]    sum_s, sum_c;
  logic signed [CW-1:0]    dx, dy;
  logic                    s_pos;
  logic        [AW:0]      rsum;
  logic        [AW-16:0]   rm;
  logic signed [YW-1:0]    ymag_ext;
  logic        [TW:0]      div_t, div_dt;
  logic                    div_ge;
  logic                    ovf_c;
  logic                    dt_zero;
  logic signed [YW-1:0]    dabs_full;
  logic signed [RW-1:0]    rate_c;
  logic                    sat_c;

  always_comb begin
    sum_s    = (2*QW+1)'(pwz_r) + (2*QW+1)'(pxy_r);
    sum_c    = (2*QW+1)'(pyy_r) + (2*QW+1)'(pzz_r);
    dx       = s_r >>> cmd.idx;
    dy       = c_r >>> cmd.idx;
    s_pos    = !s_r[CW-1] && (s_r != '0);
    rsum     = {1'b0, amag_r} + RND_HALF;
    rm       = rsum[AW:16];
    ymag_ext = signed'({1'b0, ymag_r});
    dabs_full = dw_r[YW-1] ? -dw_r : dw_r;
    div_t    = {rem_r, nsh_r[DB-1]};
    div_dt   = {1'b0, dt_r};
    div_ge   = (div_t >= div_dt);
    ovf_c    = (TW'(num_r[TW-1:DB]) >= dt_r);
    dt_zero  = (dt_r == '0);
  end

  // saturation and sign of the quotient
  always_comb begin
    rate_c = '0;
    sat_c  = 1'b0;
    if (dt_zero) begin
      rate_c = '0;
    end else if (!dneg_r) begin
      if (ovf_r || q_r[DB-1]) begin
        rate_c = RATE_MAX;
        sat_c  = 1'b1;
      end else begin
        rate_c = signed'(q_r);
      end
    end else begin
      if (ovf_r || (q_r[DB-1] && (q_r[DB-2:0] != '0))) begin
        rate_c = RATE_MIN;
        sat_c  = 1'b1;
      end else begin
        rate_c = -signed'(q_r);
      end
    end
  end

  assign sts.have_prev = have_prev_r;
  assign sts.dt_zero   = dt_zero;
  assign sts.ovf       = ovf_c;
  assign sts.out_free  = !out_valid_r || out_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.yaw_rate       = out_rate_r;
  assign out_ch.yaw_now        = out_yaw_r;
  assign out_ch.zero_interval  = out_zero_r;
  assign out_ch.rate_saturated = out_sat_r;

  // control state and stored sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_yaw_r  <= '0;
      prev_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == qyr_pkg::OP_DIFF) begin
        have_prev_r <= 1'b1;
        prev_yaw_r  <= yaw_r;
        prev_time_r <= t_r;
      end
      if (cmd.op == qyr_pkg::OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      qyr_pkg::OP_LOAD: begin
        w_r <= quat_w;
        x_r <= quat_x;
        y_r <= quat_y;
        z_r <= quat_z;
        t_r <= time_us;
      end
      qyr_pkg::OP_MUL: begin
        pwz_r <= w_r * z_r;
        pxy_r <= x_r * y_r;
        pyy_r <= y_r * y_r;
        pzz_r <= z_r * z_r;
      end
      qyr_pkg::OP_SUM: begin
        s_r <= CW'(sum_s) <<< 1;
        c_r <= C_ONE - (CW'(sum_c) <<< 1);
      end
      qyr_pkg::OP_PRE: begin
        // left half plane: rotate by pi first
        if (c_r[CW-1]) begin
          ang_r <= s_r[CW-1] ? -qyr_pkg::QYR_PI_Q29 : qyr_pkg::QYR_PI_Q29;
          c_r   <= -c_r;
          s_r   <= -s_r;
        end else begin
          ang_r <= '0;
        end
      end
      qyr_pkg::OP_ROT: begin
        if (s_pos) begin
          c_r   <= c_r + dx;
          s_r   <= s_r - dy;
          ang_r <= ang_r + qyr_pkg::atan_q29(cmd.idx);
        end else begin
          c_r   <= c_r - dx;
          s_r   <= s_r + dy;
          ang_r <= ang_r - qyr_pkg::atan_q29(cmd.idx);
        end
      end
      qyr_pkg::OP_RND1: begin
        aneg_r <= ang_r[AW-1];
        amag_r <= ang_r[AW-1] ? unsigned'(-ang_r) : unsigned'(ang_r);
      end
      qyr_pkg::OP_RND2: begin
        ymag_r <= (rm > PI_RM) ? MW'(qyr_pkg::QYR_PI_Q13) : rm[MW-1:0];
      end
      qyr_pkg::OP_YAW: begin
        yaw_r <= aneg_r ? -ymag_ext : ymag_ext;
      end
      qyr_pkg::OP_DIFF: begin
        d_r  <= (YW+1)'(yaw_r) - (YW+1)'(prev_yaw_r);
        dt_r <= t_r - prev_time_r;
      end
      qyr_pkg::OP_WRAP: begin
        if (d_r > (YW+1)'(qyr_pkg::QYR_PI_Q13)) begin
          dw_r <= YW'(d_r - qyr_pkg::QYR_TWO_PI_Q13);
        end else if (d_r < -(YW+1)'(qyr_pkg::QYR_PI_Q13)) begin
          dw_r <= YW'(d_r + qyr_pkg::QYR_TWO_PI_Q13);
        end else begin
          dw_r <= YW'(d_r);
        end
      end
      qyr_pkg::OP_MAG: begin
        dneg_r <= dw_r[YW-1];
        dabs_r <= dabs_full[MW-1:0];
      end
      qyr_pkg::OP_MULT: begin
        prod_r <= PW'(dabs_r) * qyr_pkg::QYR_RATE_SCALE;
      end
      qyr_pkg::OP_NUM: begin
        // add dt/2 so the quotient rounds half up
        num_r <= TW'(prod_r) + (dt_r >> 1);
      end
      qyr_pkg::OP_SETUP: begin
        ovf_r <= ovf_c;
        rem_r <= TW'(num_r[TW-1:DB]);
        nsh_r <= num_r[DB-1:0];
        q_r   <= '0;
      end
      qyr_pkg::OP_DIV: begin
        // one restoring step per cycle, remainder stays below dt
        rem_r <= div_ge ? TW'(div_t - div_dt) : div_t[TW-1:0];
        nsh_r <= {nsh_r[DB-2:0], 1'b0};
        q_r   <= {q_r[DB-2:0], div_ge};
      end
      qyr_pkg::OP_OUT: begin
        out_rate_r <= rate_c;
        out_yaw_r  <= yaw_r;
        out_zero_r <= dt_zero;
        out_sat_r  <= sat_c;
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/quaternion_yaw_rate.sv]
// quaternion yaw rate: top level joining the sequencer and the datapath
//
// in_ch carries one orientation quaternion (Q1.15 w, x, y, z) and a 48-bit
// microsecond timestamp per item; out_ch carries the yaw rate (Q16.16 rad/s,
// saturated), the current yaw (Q3.13 rad) and the zero-interval and
// saturation flags. Both channels move an item when valid and ready are high.
// Items are processed one at a time: each passes the cordic loop and the
// 32-step restoring divider; a zero interval or a rate that overflows the
// quotient skips the divider. in_ch.ready rises together with out_ch.valid,
// so the next item is taken no earlier than the result of the last one is
// offered. The first item after reset only stores yaw and time and gives no
// result. Reset clears the stored sample and the valid flag of the output
// register. A finished result waits in the output register while the next
// item is taken and processed; only loading the following result waits for
// out_ch.ready.
`include "assert_macros.svh"

module quaternion_yaw_rate #(
  parameter int CORDIC_STEPS = qyr_pkg::QYR_CORDIC_STEPS
) (
  input logic        clk,
  input logic        rst_n,
  qyr_in_if.sink     in_ch,
  qyr_out_if.source  out_ch
);

  qyr_pkg::qyr_cmd_t cmd;
  qyr_pkg::qyr_sts_t sts;
  logic              in_ready;

  assign in_ch.ready = in_ready;

  qyr_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  qyr_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .quat_w  (in_ch.quat_w),
    .quat_x  (in_ch.quat_x),
    .quat_y  (in_ch.quat_y),
    .quat_z  (in_ch.quat_z),
    .time_us (in_ch.time_us),
    .sts     (sts),
    .out_ch  (out_ch)
  );

  // the block is busy right after taking an item
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready)

  // a zero interval always reports rate 0 without saturation
  `ASSERT_IMPL(a_zero_rate, clk, rst_n, out_ch.valid && out_ch.zero_interval,
               out_ch.yaw_rate == '0 && !out_ch.rate_saturated)

  // yaw stays within plus or minus pi
  `ASSERT_IMPL(a_yaw_range, clk, rst_n, out_ch.valid,
               out_ch.yaw_now <= qyr_pkg::QYR_PI_Q13 &&
               out_ch.yaw_now >= -qyr_pkg::QYR_PI_Q13)

endmodule

[verif/tb_top.sv]
// self-checking testbench of the quaternion yaw rate block
`timescale 1ns / 100ps

module tb_top;

  localparam int STEPS     = qyr_pkg::QYR_CORDIC_STEPS;
  localparam int N_RANDOM  = 1400;
  localparam int DRAIN_AT  = 700;   // random item that waits for an empty pipe
  localparam int HOLD_AT   = 300;   // results seen before the long receiver hold
  localparam int HOLD_LEN  = 600;
  localparam longint PI_Q29     = 64'sd1686629713;
  localparam longint PI_Q13     = 64'sd25736;
  localparam longint TWO_PI_Q13 = 64'sd51472;
  localparam longint unsigned RATE_SCALE = 64'd8000000;

  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic [47:0]        stamp;
    logic               drain;
  } pose_item_t;

  typedef struct packed {
    logic signed [31:0] rate;
    logic signed [15:0] yaw;
    logic               zero;
    logic               sat;
  } yaw_rate_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  qyr_in_if  in_if();
  qyr_out_if out_if();

  quaternion_yaw_rate #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #5 clk = ~clk;

  // atan(2^-i) at scale 2^29
  longint atan_step_q29 [24] = '{
    421657428, 248918915, 131521918, 66762579,
    33510843, 16771758, 8387925, 4194219,
    2097141, 1048575, 524288, 262144,
    131072, 65536, 32768, 16384,
    8192, 4096, 2048, 1024,
    512, 256, 128, 64
  };

  pose_item_t pending_poses[$];
  yaw_rate_t  pending_rates[$];
  pose_item_t on_bus;

  logic signed [15:0] last_yaw;
  logic [47:0]        last_stamp;
  logic               seen_pose;

  int items_taken;
  int results_seen;
  int error_count;
  int send_idle;
  int recv_idle;
  int hold_left;
  bit hold_done;

  function automatic logic signed [15:0] cordic_yaw(
    input logic signed [15:0] w, x, y, z
  );
    longint s, c, ang, r, dx, dy;
    int steps;
    int i;
    s = 2 * (longint'(w) * longint'(z) + longint'(x) * longint'(y));
    c = (64'sd1 <<< 30) - 2 * (longint'(y) * longint'(y) + longint'(z) * longint'(z));
    ang = 0;
    steps = (STEPS > 24) ? 24 : STEPS;
    // left half plane: rotate by pi first
    if (c < 0) begin
      ang = (s >= 0) ? PI_Q29 : -PI_Q29;
      c = -c;
      s = -s;
    end
    for (i = 0; i < steps; i++) begin
      dx = s >>> i;
      dy = c >>> i;
      if (s > 0) begin
        c = c + dx;
        s = s - dy;
        ang = ang + atan_step_q29[i];
      end else begin
        c = c - dx;
        s = s + dy;
        ang = ang - atan_step_q29[i];
      end
    end
    if (ang >= 0) r = (ang + 32768) >>> 16;
    else r = -((-ang + 32768) >>> 16);
    if (r > PI_Q13) r = PI_Q13;
    if (r < -PI_Q13) r = -PI_Q13;
    return r[15:0];
  endfunction

  task automatic track_pose(input pose_item_t p);
    logic signed [15:0] yaw;
    logic [47:0]        span;
    longint             d, rate_l;
    longint unsigned    mag, q, span_l;
    yaw_rate_t          e;
    yaw = cordic_yaw(p.w, p.x, p.y, p.z);
    if (!seen_pose) begin
      seen_pose = 1'b1;
    end else begin
      span = p.stamp - last_stamp;
      d = longint'(yaw) - longint'(last_yaw);
      if (d > PI_Q13) d = d - TWO_PI_Q13;
      else if (d < -PI_Q13) d = d + TWO_PI_Q13;
      e.yaw = yaw;
      e.zero = 1'b0;
      e.sat = 1'b0;
      rate_l = 0;
      if (span == '0) begin
        e.zero = 1'b1;
      end else begin
        span_l = {16'd0, span};
        mag = longint'(d < 0 ? -d : d) * RATE_SCALE;
        q = (mag + span_l / 2) / span_l;
        if (d >= 0) begin
          if (q > 64'd2147483647) begin
            q = 64'd2147483647;
            e.sat = 1'b1;
          end
          rate_l = longint'(q);
        end else begin
          if (q > 64'd2147483648) begin
            q = 64'd2147483648;
            e.sat = 1'b1;
          end
          rate_l = -longint'(q);
        end
      end
      e.rate = rate_l[31:0];
      pending_rates.push_back(e);
    end
    last_yaw = yaw;
    last_stamp = p.stamp;
  endtask

  task automatic note_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  function automatic bit calm_phase();
    return items_taken >= 200 && items_taken < 400;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_pose(
    input int w, x, y, z, input logic [47:0] stamp, input bit drain = 1'b0
  );
    pose_item_t p;
    p.w = w[15:0];
    p.x = x[15:0];
    p.y = y[15:0];
    p.z = z[15:0];
    p.stamp = stamp;
    p.drain = drain;
    pending_poses.push_back(p);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_idle = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        track_pose(on_bus);
        items_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_idle > 0) begin
          send_idle--;
          in_if.valid <= 1'b0;
        end else if (pending_poses.size() != 0 &&
                     !(pending_poses[0].drain && pending_rates.size() != 0)) begin
          on_bus = pending_poses.pop_front();
          in_if.valid   <= 1'b1;
          in_if.quat_w  <= on_bus.w;
          in_if.quat_x  <= on_bus.x;
          in_if.quat_y  <= on_bus.y;
          in_if.quat_z  <= on_bus.z;
          in_if.time_us <= on_bus.stamp;
          send_idle = pick_gap(calm_phase());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_idle = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_if.ready <= 1'b0;
    end else if (recv_idle > 0) begin
      recv_idle--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      recv_idle = pick_gap(calm_phase());
    end
  end

  // result checker
  always @(posedge clk) begin
    yaw_rate_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_rates.size() == 0) begin
        note_failure($sformatf("unexpected result: rate %0d yaw %0d zero %0b sat %0b",
                               out_if.yaw_rate, out_if.yaw_now, out_if.zero_interval,
                               out_if.rate_saturated));
      end else begin
        e = pending_rates.pop_front();
        if (out_if.yaw_rate !== e.rate || out_if.yaw_now !== e.yaw ||
            out_if.zero_interval !== e.zero || out_if.rate_saturated !== e.sat) begin
          note_failure($sformatf(
            "result %0d: exp rate %0d yaw %0d z %0b s %0b, got rate %0d yaw %0d z %0b s %0b",
            results_seen, e.rate, e.yaw, e.zero, e.sat, out_if.yaw_rate, out_if.yaw_now,
            out_if.zero_interval, out_if.rate_saturated));
        end
      end
    end
  end

  initial begin
    logic [47:0] t;
    int n, sel, k;
    int w, x, y, z;
    in_if.valid = 1'b0;
    in_if.quat_w = '0;
    in_if.quat_x = '0;
    in_if.quat_y = '0;
    in_if.quat_z = '0;
    in_if.time_us = '0;
    out_if.ready = 1'b0;
    seen_pose = 1'b0;
    last_yaw = '0;
    last_stamp = '0;
    items_taken = 0;
    results_seen = 0;
    error_count = 0;

    // first item only stores, then a repeated timestamp
    t = 48'd1000;
    queue_pose(32767, 0, 0, 0, t);
    queue_pose(32767, 0, 0, 0, t);
    // s = c = 0
    t = t + 1000;
    queue_pose(0, 0, 16384, 16384, t);
    // c < 0 with s = 0, then s < 0
    t = t + 1;
    queue_pose(0, 0, 32767, 0, t);
    t = t + 1;
    queue_pose(1000, 0, 0, -32768, t);
    t = t + 1;
    queue_pose(-32768, -32768, -32768, -32768, t);
    t = t + 1;
    queue_pose(32767, 32767, 32767, 32767, t);
    t = t + 50;
    queue_pose(32767, -32768, 32767, -32768, t);
    // half-turn swings with a tiny interval saturate both ways
    t = t + 1000;
    queue_pose(23170, 0, 0, 23170, t);
    t = t + 1;
    queue_pose(23170, 0, 0, -23170, t);
    t = t + 1;
    queue_pose(23170, 0, 0, 23170, t);
    // across the +-pi seam
    t = t + 100000;
    queue_pose(2000, 0, 0, 32700, t);
    t = t + 100000;
    queue_pose(2000, 0, 0, -32700, t);
    t = t + 100000;
    queue_pose(2000, 0, 0, 32700, t);
    // timestamp going backward
    t = t - 5000;
    queue_pose(0, 32767, 0, 0, t);
    // timestamp wraps through the top
    t = 48'hFFFF_FFFF_FFFF;
    queue_pose(0, 0, 32767, 0, t);
    t = 48'd0;
    queue_pose(0, 0, 0, 32767, t);
    t = t + 48'h8000_0000_0000;
    queue_pose(-32768, 0, 0, 0, t);
    t = t + 48'h7FFF_FFFF_FFFF;
    queue_pose(0, -32768, 0, 0, t);
    queue_pose(0, 0, 0, 0, t + 3);

    t = t + 3;
    for (n = 0; n < N_RANDOM; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        w = $urandom; x = $urandom; y = $urandom; z = $urandom;
      end else if (sel < 75) begin
        k = $urandom_range(0, 4000); w = k - 2000;
        k = $urandom_range(0, 4000); x = k - 2000;
        k = $urandom_range(0, 4000); y = k - 2000;
        k = $urandom_range(0, 4000); z = k - 2000;
      end else begin
        // rotation about the vertical axis only
        w = $urandom; x = 0; y = 0; z = $urandom;
      end
      sel = $urandom_range(0, 99);
      if (sel < 55) t = t + $urandom_range(1000, 100000);
      else if (sel < 70) t = t + $urandom_range(1, 200);
      else if (sel < 75) t = t;
      else if (sel < 80) t = t - $urandom_range(1, 1000000);
      else if (sel < 85) t = 48'({$urandom, $urandom});
      else t = t + {16'd0, $urandom};
      queue_pose(w, x, y, z, t, n == DRAIN_AT);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_poses.size() != 0 || in_if.valid) @(posedge clk);
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/qyr_pkg.sv
hw/rtl/qyr_ifs.sv
hw/rtl/qyr_ctrl.sv
hw/rtl/qyr_dp.sv
hw/rtl/quaternion_yaw_rate.sv
verif/tb_top.sv
